FILE: src/vff_pkg.sv
// ----------------------------------------------------------------------------
// Valley floor flattening package
// Shared constants, codes, command and status types and helper functions.
// ----------------------------------------------------------------------------
package vff_pkg;

  localparam int MAX_DIM   = 64;
  localparam int WIN_R     = 10;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int DIM_W     = COORD_W + 1;
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int H_W       = 16;
  localparam int STR_W     = 9;
  localparam int WIN_N     = 2 * WIN_R + 1;
  localparam int OFF_W     = $clog2(WIN_N);
  localparam int SUM_W     = COORD_W + OFF_W + 2;
  localparam int K_W       = 23;
  localparam int P1_W      = H_W + STR_W;
  localparam int NUM_W     = P1_W + K_W;
  localparam int DEN_W     = 31;
  localparam int DCNT_W    = $clog2(NUM_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [OFF_W-1:0]        WIN_LAST  = OFF_W'(WIN_N - 1);
  localparam logic signed [SUM_W-1:0] WIN_R_S   = SUM_W'(WIN_R);
  localparam logic [DCNT_W-1:0]       DCNT_LAST = DCNT_W'(NUM_W - 1);

  localparam logic [STR_W-1:0] STR_ONE   = 9'd256;
  localparam logic [STR_W-1:0] STR_MIN   = 9'd3;
  localparam logic [K_W-1:0]   FRAC_BASE = 23'd85;
  localparam logic [K_W-1:0]   FRAC_SPAN = 23'd15;
  localparam logic [DEN_W-1:0] DEN_SCALE = 31'd25600;

  localparam logic [H_W-1:0]   RST_THRESHOLD = 16'd32768;
  localparam logic [STR_W-1:0] RST_STRENGTH  = 9'd128;
  localparam logic [DIM_W-1:0] RST_WIDTH     = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] RST_HEIGHT    = DIM_W'(MAX_DIM);

  typedef enum logic {
    FUNC_STORE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_STRENGTH  = 2'd1,
    CFG_WIDTH     = 2'd2,
    CFG_HEIGHT    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [H_W-1:0]     height_in;
  } in_item_t;

  typedef struct packed {
    logic store;
    logic load_pos;
    logic rd_centre;
    logic capture;
    logic scan_step;
    logic mul1;
    logic mul2;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic scan_last;
    logic div_last;
    logic out_free;
  } sts_t;

  function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] m;
    m = v - DIM_W'(1);
    if (v == '0) begin
      return '0;
    end else if (v > DIM_W'(MAX_DIM)) begin
      return COORD_W'(MAX_DIM - 1);
    end
    return m[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
                                                    input logic [COORD_W-1:0] hi);
    logic signed [SUM_W-1:0] hi_s;
    hi_s = $signed({{(SUM_W-COORD_W){1'b0}}, hi});
    if (v < 0) begin
      return '0;
    end else if (v > hi_s) begin
      return hi;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

FILE: src/vff_if.sv
// ----------------------------------------------------------------------------
// Valley floor flattening channels
// Request channel carrying store and query items, and result channel.
// ----------------------------------------------------------------------------
interface vff_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [vff_pkg::COORD_W-1:0] col;
  logic [vff_pkg::COORD_W-1:0] row;
  logic [vff_pkg::H_W-1:0]     height_in;

  modport source (output valid, func, col, row, height_in, input ready);
  modport sink   (input valid, func, col, row, height_in, output ready);
endinterface

interface vff_out_if;
  logic                    valid;
  logic                    ready;
  logic [vff_pkg::H_W-1:0] flat_height;
  logic                    is_valley;

  modport source (output valid, flat_height, is_valley, input ready);
  modport sink   (input valid, flat_height, is_valley, output ready);
endinterface

FILE: src/vff_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/vff_datapath.sv
// ----------------------------------------------------------------------------
// Valley floor flattening datapath
// Configuration registers, height store, window scan, floor search,
// multipliers, shift-subtract divider and result register.
// ----------------------------------------------------------------------------
module vff_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vff_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [vff_pkg::CFG_W-1:0]     cfg_data,
  input  vff_pkg::in_item_t             in_item,
  input  vff_pkg::cmd_t                 cmd,
  output vff_pkg::sts_t                 sts,
  vff_out_if.source                     out_ch
);

  localparam int CW = vff_pkg::COORD_W;
  localparam int HW = vff_pkg::H_W;

  logic [HW-1:0]               thr_r;
  logic [vff_pkg::STR_W-1:0]   str_r;
  logic [vff_pkg::DIM_W-1:0]   wid_r;
  logic [vff_pkg::DIM_W-1:0]   hgt_r;

  logic [CW-1:0]               x_r, y_r, x_nxt, y_nxt;
  logic [CW-1:0]               x_last, y_last;
  logic [vff_pkg::OFF_W-1:0]   dx_r, dy_r;
  logic signed [vff_pkg::SUM_W-1:0] sx, sy;
  logic [CW-1:0]               nx, ny;
  logic [vff_pkg::ADDR_W-1:0]  raddr;
  logic [HW-1:0]               rdata;
  logic                        cmp_v_r;

  logic [HW-1:0]               h_r, fl_r;
  logic                        valley_r;
  logic [vff_pkg::STR_W-1:0]   s_sat;
  logic [HW-1:0]               dd, dt;
  logic [vff_pkg::P1_W-1:0]    p1_r;
  logic [vff_pkg::K_W-1:0]     k_r;
  logic [vff_pkg::NUM_W-1:0]   num_r;
  logic [vff_pkg::DEN_W-1:0]   den_r;
  logic [vff_pkg::DEN_W-1:0]   rem_r;
  logic [vff_pkg::DEN_W:0]     trial;
  logic [HW-1:0]               q_r;
  logic [vff_pkg::DCNT_W-1:0]  dcnt_r;
  logic [HW:0]                 drop;
  logic [HW-1:0]               result;

  logic                        out_valid_r;
  logic [HW-1:0]               out_flat_r;
  logic                        out_valley_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= vff_pkg::RST_THRESHOLD;
      str_r <= vff_pkg::RST_STRENGTH;
      wid_r <= vff_pkg::RST_WIDTH;
      hgt_r <= vff_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vff_pkg::CFG_THRESHOLD: thr_r <= cfg_data[HW-1:0];
        vff_pkg::CFG_STRENGTH:  str_r <= cfg_data[vff_pkg::STR_W-1:0];
        vff_pkg::CFG_WIDTH:     wid_r <= cfg_data[vff_pkg::DIM_W-1:0];
        vff_pkg::CFG_HEIGHT:    hgt_r <= cfg_data[vff_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign x_last = vff_pkg::dim_last(wid_r);
  assign y_last = vff_pkg::dim_last(hgt_r);
  assign x_nxt  = (in_item.col > x_last) ? x_last : in_item.col;
  assign y_nxt  = (in_item.row > y_last) ? y_last : in_item.row;

  assign sx = $signed({{(vff_pkg::SUM_W-CW){1'b0}}, x_r})
            + $signed({{(vff_pkg::SUM_W-vff_pkg::OFF_W){1'b0}}, dx_r}) - vff_pkg::WIN_R_S;
  assign sy = $signed({{(vff_pkg::SUM_W-CW){1'b0}}, y_r})
            + $signed({{(vff_pkg::SUM_W-vff_pkg::OFF_W){1'b0}}, dy_r}) - vff_pkg::WIN_R_S;
  assign nx = vff_pkg::clamp_pos(sx, x_last);
  assign ny = vff_pkg::clamp_pos(sy, y_last);

  assign raddr = cmd.rd_centre ? {y_r, x_r} : {ny, nx};

  vff_ram #(
    .WIDTH (HW),
    .DEPTH (vff_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr ({in_item.row, in_item.col}),
    .wdata (in_item.height_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign s_sat = (str_r > vff_pkg::STR_ONE) ? vff_pkg::STR_ONE : str_r;
  assign dd    = h_r - fl_r;
  assign dt    = thr_r - h_r;
  assign trial = {rem_r, num_r[vff_pkg::NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
      dx_r    <= '0;
      dy_r    <= '0;
      dcnt_r  <= '0;
    end else begin
      cmp_v_r <= cmd.scan_step;
      if (cmd.capture) begin
        dx_r <= '0;
        dy_r <= '0;
      end else if (cmd.scan_step) begin
        if (dx_r == vff_pkg::WIN_LAST) begin
          dx_r <= '0;
          dy_r <= dy_r + vff_pkg::OFF_W'(1);
        end else begin
          dx_r <= dx_r + vff_pkg::OFF_W'(1);
        end
      end
      if (cmd.mul2) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + vff_pkg::DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
    if (cmd.capture) begin
      h_r      <= rdata;
      fl_r     <= rdata;
      valley_r <= (rdata < thr_r);
    end else if (cmp_v_r && (rdata < thr_r) && (rdata < fl_r)) begin
      fl_r <= rdata;
    end
    if (cmd.mul1) begin
      p1_r <= vff_pkg::P1_W'(dd) * vff_pkg::P1_W'(s_sat);
      k_r  <= vff_pkg::K_W'(thr_r) * vff_pkg::FRAC_BASE
            + vff_pkg::K_W'(dt) * vff_pkg::FRAC_SPAN;
    end
    if (cmd.mul2) begin
      num_r <= vff_pkg::NUM_W'(p1_r) * vff_pkg::NUM_W'(k_r);
      den_r <= vff_pkg::DEN_W'(thr_r) * vff_pkg::DEN_SCALE;
    end
    if (cmd.capture || cmd.mul2) begin
      rem_r <= '0;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[vff_pkg::NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_r <= vff_pkg::DEN_W'(trial - {1'b0, den_r});
        q_r   <= {q_r[HW-2:0], 1'b1};
      end else begin
        rem_r <= trial[vff_pkg::DEN_W-1:0];
        q_r   <= {q_r[HW-2:0], 1'b0};
      end
    end
  end

  // The quotient never exceeds h minus floor, so sixteen bits hold it.
  assign drop   = {1'b0, q_r} + {{HW{1'b0}}, (rem_r != '0)};
  assign result = (drop >= {1'b0, h_r}) ? '0 : h_r - drop[HW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flat_r   <= result;
      out_valley_r <= valley_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.flat_height = out_flat_r;
  assign out_ch.is_valley   = out_valley_r;

  assign sts.pass      = !(rdata < thr_r) || (s_sat < vff_pkg::STR_MIN);
  assign sts.scan_last = (dx_r == vff_pkg::WIN_LAST) && (dy_r == vff_pkg::WIN_LAST);
  assign sts.div_last  = (dcnt_r == vff_pkg::DCNT_LAST);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

endmodule

FILE: src/vff_ctrl.sv
// ----------------------------------------------------------------------------
// Valley floor flattening controller
// Sequences stores, the centre read, the window scan, the multiplications,
// the division and the hand-over of the result.
// ----------------------------------------------------------------------------
module vff_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  vff_in_if.sink        in_ch,
  input  vff_pkg::sts_t sts,
  output vff_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RD_CTR   = 9'b000000010,
    S_CAPTURE  = 9'b000000100,
    S_SCAN     = 9'b000001000,
    S_SCAN_END = 9'b000010000,
    S_MUL1     = 9'b000100000,
    S_MUL2     = 9'b001000000,
    S_DIV      = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ch.ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.func == vff_pkg::FUNC_STORE) begin
            cmd.store = 1'b1;
          end else begin
            cmd.load_pos = 1'b1;
            state_nxt    = S_RD_CTR;
          end
        end
      end
      S_RD_CTR: begin
        cmd.rd_centre = 1'b1;
        state_nxt     = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd.capture = 1'b1;
        state_nxt   = sts.pass ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: src/valley_floor_flattening.sv
// ----------------------------------------------------------------------------
// Valley floor flattening
// A store writes the height store while idle. A valley query runs from
// acceptance to a valid result through the 441 window reads through the single
// read port of the height store and the 48-step divider, which a query that
// passes through skips; no new item is taken until the result is loaded. Reset
// restores the registers to their defaults; the height store is not cleared.
// ----------------------------------------------------------------------------
module valley_floor_flattening (
  input  logic                          clk,
  input  logic                          rst_n,
  vff_in_if.sink                        in_ch,
  vff_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [vff_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [vff_pkg::CFG_W-1:0]     cfg_data
);

  vff_pkg::cmd_t     cmd;
  vff_pkg::sts_t     sts;
  vff_pkg::in_item_t in_item;

  assign in_item.col       = in_ch.col;
  assign in_item.row       = in_ch.row;
  assign in_item.height_in = in_ch.height_in;

  vff_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .sts   (sts),
    .cmd   (cmd)
  );

  vff_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

endmodule
